[sv/vde_pkg.sv]
package vde_pkg;

    localparam int ELEM_W  = 16;
    localparam int SUM_W   = 48;
    localparam int ABS_W   = 32;
    localparam int CNT_W   = 13;
    localparam int DIST_W  = 46;
    localparam int FRAC_W  = 16;
    localparam int MET_W   = 3;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int ROOT_W  = 32;
    localparam int DEN_W   = 2 * ROOT_W;
    localparam int Q_W     = 16;

    // metric codes
    localparam logic [MET_W-1:0] MET_L2SQ = 3'd0;
    localparam logic [MET_W-1:0] MET_L2   = 3'd1;
    localparam logic [MET_W-1:0] MET_COS  = 3'd2;
    localparam logic [MET_W-1:0] MET_NIP  = 3'd3;
    localparam logic [MET_W-1:0] MET_L1   = 3'd4;
    localparam logic [MET_W-1:0] MET_HAM  = 3'd5;

    localparam logic [MET_W-1:0] METRIC_RESET = MET_L2;

    // register index (paddr[2])
    localparam logic REG_METRIC = 1'b0;

    localparam logic signed [SUM_W:0] ONE_Q16  = 49'sd65536;
    localparam logic signed [SUM_W:0] OUT_HIGH = 49'sd17592186044416;
    localparam logic signed [SUM_W:0] OUT_LOW  = -49'sd8796093022208;

    typedef enum logic [1:0] {
        SQ_SRC_DIFF,
        SQ_SRC_NA,
        SQ_SRC_NB
    } sq_src_t;

    typedef struct packed {
        logic    accept;
        logic    sq_start;
        sq_src_t sq_src;
        logic    save_ra;
        logic    mul_go;
        logic    div_start;
        logic    out_load;
    } vde_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic sq_busy;
        logic div_busy;
    } vde_stat_t;

    function automatic logic signed [DIST_W-1:0] sat_dist(input logic signed [SUM_W:0] v);
        logic signed [SUM_W:0] r;
        begin
            if (v > OUT_HIGH)
            begin
                r = OUT_HIGH;
            end
            else if (v < OUT_LOW)
            begin
                r = OUT_LOW;
            end
            else
            begin
                r = v;
            end
            return r[DIST_W-1:0];
        end
    endfunction

endpackage

[sv/vector_distance_engine_core.sv]
// Throughput: one element word per cycle while a vector streams in; the block stalls
// input from the last word until its distance sits in the output register.
// Squared L2, inner product, L1 and Hamming are taken from the sums directly; L2 adds
// a bit-serial square root; cosine adds two square roots, one multiply and a
// shift-subtract divide.
// Reset (rst_n low, async): sums cleared, metric_reg = L2, no word pending.
module vector_distance_engine_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [vde_pkg::PADDR_W-1:0]         paddr,
    input  logic [vde_pkg::PDATA_W-1:0]         pwdata,
    output logic [vde_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [vde_pkg::ELEM_W-1:0]   elem_a,
    input  logic signed [vde_pkg::ELEM_W-1:0]   elem_b,
    input  logic                                last_elem,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [vde_pkg::DIST_W-1:0]   distance
);
    import vde_pkg::*;

    logic [MET_W-1:0] metric_reg;
    logic [MET_W-1:0] metric_next;
    vde_cmd_t         cmd;
    vde_stat_t        stat;

    always_comb
    begin
        metric_next = metric_reg;
        if (psel && penable && pwrite && paddr[2] == REG_METRIC)
        begin
            metric_next = pwdata[MET_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg <= METRIC_RESET;
        end
        else
        begin
            metric_reg <= metric_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_METRIC) ? PDATA_W'(metric_reg) : '0;

    vde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .metric    (metric_reg),
        .in_valid  (in_valid),
        .last_elem (last_elem),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    vde_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .metric   (metric_reg),
        .elem_a   (elem_a),
        .elem_b   (elem_b),
        .stat     (stat),
        .distance (distance)
    );

endmodule

[sv/vde_isqrt.sv]
module vde_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [2*vde_pkg::ROOT_W-1:0] radicand,
    output logic                       busy,
    output logic [vde_pkg::ROOT_W-1:0] root
);
    import vde_pkg::*;

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_BITS = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]    rad_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [CNT_BITS-1:0] cnt_reg;

    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             fits;

    // one result bit per cycle, two radicand bits shifted in
    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        fits   = (rem_sh >= trial);
        diff   = rem_sh - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_BITS'(ROOT_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign busy = (cnt_reg != '0);
    assign root = root_reg;

endmodule

[sv/vde_datapath.sv]
module vde_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  vde_pkg::vde_cmd_t                   cmd,
    input  logic [vde_pkg::MET_W-1:0]           metric,
    input  logic signed [vde_pkg::ELEM_W-1:0]   elem_a,
    input  logic signed [vde_pkg::ELEM_W-1:0]   elem_b,
    output vde_pkg::vde_stat_t                  stat,
    output logic signed [vde_pkg::DIST_W-1:0]   distance
);
    import vde_pkg::*;

    localparam int PROD_W = 2 * ELEM_W;

    // stage 1: operands
    logic                     v1_reg;
    logic signed [ELEM_W-1:0] a1_reg;
    logic signed [ELEM_W-1:0] b1_reg;
    logic [ELEM_W-1:0]        ad1_reg;
    logic                     ne1_reg;

    // stage 2: products
    logic                     v2_reg;
    logic signed [PROD_W-1:0] p_ab_reg;
    logic [PROD_W-1:0]        p_aa_reg;
    logic [PROD_W-1:0]        p_bb_reg;
    logic [PROD_W-1:0]        p_dd_reg;
    logic [ELEM_W-1:0]        ad2_reg;
    logic                     ne2_reg;

    // running sums
    logic signed [SUM_W-1:0] dot_reg;
    logic [SUM_W-1:0]        na_reg;
    logic [SUM_W-1:0]        nb_reg;
    logic [SUM_W-1:0]        dsq_reg;
    logic [ABS_W-1:0]        abs_reg;
    logic [CNT_W-1:0]        cnt_reg;

    logic signed [SUM_W-1:0] dot_next;
    logic [SUM_W-1:0]        na_next;
    logic [SUM_W-1:0]        nb_next;
    logic [SUM_W-1:0]        dsq_next;
    logic [ABS_W-1:0]        abs_next;

    logic signed [ELEM_W:0]  d;
    logic [ELEM_W-1:0]       ad;
    logic signed [SUM_W:0]   dot_s;
    logic [SUM_W:0]          na_s;
    logic [SUM_W:0]          nb_s;
    logic [SUM_W:0]          dsq_s;
    logic [ABS_W:0]          abs_s;

    // final stage
    logic [DEN_W-1:0]   sq_rad;
    logic               sq_busy;
    logic [ROOT_W-1:0]  sq_root;
    logic [ROOT_W-1:0]  ra_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [DEN_W-1:0]   div_r_reg;
    logic [Q_W-1:0]     q_reg;
    logic [4:0]         dcnt_reg;
    logic [DEN_W:0]     r2;
    logic [SUM_W-1:0]   mag;
    logic [DEN_W-1:0]   num;
    logic [Q_W:0]       sim;
    logic signed [SUM_W:0] cos_val;
    logic signed [SUM_W:0] res;
    logic signed [DIST_W-1:0] distance_reg;

    always_comb
    begin
        d  = {elem_a[ELEM_W-1], elem_a} - {elem_b[ELEM_W-1], elem_b};
        ad = d[ELEM_W] ? ELEM_W'(-d) : d[ELEM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.accept;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            a1_reg  <= elem_a;
            b1_reg  <= elem_b;
            ad1_reg <= ad;
            ne1_reg <= (elem_a != elem_b);
        end
        if (v1_reg)
        begin
            p_ab_reg <= a1_reg * b1_reg;
            p_aa_reg <= $unsigned(PROD_W'(a1_reg) * PROD_W'(a1_reg));
            p_bb_reg <= $unsigned(PROD_W'(b1_reg) * PROD_W'(b1_reg));
            p_dd_reg <= ad1_reg * ad1_reg;
            ad2_reg  <= ad1_reg;
            ne2_reg  <= ne1_reg;
        end
    end

    // saturating accumulate
    always_comb
    begin
        dot_s = {dot_reg[SUM_W-1], dot_reg} + (SUM_W+1)'(p_ab_reg);
        na_s  = {1'b0, na_reg} + (SUM_W+1)'(p_aa_reg);
        nb_s  = {1'b0, nb_reg} + (SUM_W+1)'(p_bb_reg);
        dsq_s = {1'b0, dsq_reg} + (SUM_W+1)'(p_dd_reg);
        abs_s = {1'b0, abs_reg} + (ABS_W+1)'(ad2_reg);

        if (dot_s[SUM_W] != dot_s[SUM_W-1])
        begin
            dot_next = dot_s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            dot_next = dot_s[SUM_W-1:0];
        end
        na_next  = na_s[SUM_W]  ? '1 : na_s[SUM_W-1:0];
        nb_next  = nb_s[SUM_W]  ? '1 : nb_s[SUM_W-1:0];
        dsq_next = dsq_s[SUM_W] ? '1 : dsq_s[SUM_W-1:0];
        abs_next = abs_s[ABS_W] ? '1 : abs_s[ABS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
            dsq_reg <= '0;
            abs_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.out_load)
        begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
            dsq_reg <= '0;
            abs_reg <= '0;
            cnt_reg <= '0;
        end
        else if (v2_reg)
        begin
            dot_reg <= dot_next;
            na_reg  <= na_next;
            nb_reg  <= nb_next;
            dsq_reg <= dsq_next;
            abs_reg <= abs_next;
            if (ne2_reg && cnt_reg != '1)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        case (cmd.sq_src)
            SQ_SRC_NA: sq_rad = {na_reg, {FRAC_W{1'b0}}};
            SQ_SRC_NB: sq_rad = {nb_reg, {FRAC_W{1'b0}}};
            default:   sq_rad = {dsq_reg, {FRAC_W{1'b0}}};
        endcase
    end

    vde_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sq_start),
        .radicand (sq_rad),
        .busy     (sq_busy),
        .root     (sq_root)
    );

    // cosine: den = ra * rb, then 16 quotient bits of |dot| * 2^32 / den
    always_comb
    begin
        mag = dot_reg[SUM_W-1] ? SUM_W'(-dot_reg) : dot_reg;
        num = {mag, {FRAC_W{1'b0}}};
        r2  = {div_r_reg, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            dcnt_reg <= 5'(Q_W);
        end
        else if (dcnt_reg != '0)
        begin
            dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.save_ra)
        begin
            ra_reg <= sq_root;
        end
        if (cmd.mul_go)
        begin
            den_reg <= ra_reg * sq_root;
        end
        if (cmd.div_start)
        begin
            div_r_reg <= num;
            q_reg     <= '0;
        end
        else if (dcnt_reg != '0)
        begin
            if (r2 >= {1'b0, den_reg})
            begin
                div_r_reg <= DEN_W'(r2 - {1'b0, den_reg});
                q_reg     <= {q_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                div_r_reg <= r2[DEN_W-1:0];
                q_reg     <= {q_reg[Q_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        sim = (num >= den_reg) ? 17'h10000 : {1'b0, q_reg};
        if (den_reg == '0)
        begin
            cos_val = ONE_Q16;
        end
        else if (dot_reg[SUM_W-1])
        begin
            cos_val = ONE_Q16 + $signed((SUM_W+1)'(sim));
        end
        else
        begin
            cos_val = ONE_Q16 - $signed((SUM_W+1)'(sim));
        end

        case (metric)
            MET_L2SQ: res = $signed({1'b0, dsq_reg});
            MET_COS:  res = cos_val;
            MET_NIP:  res = -$signed({dot_reg[SUM_W-1], dot_reg});
            MET_L1:   res = $signed((SUM_W+1)'({abs_reg, 8'b0}));
            MET_HAM:  res = $signed((SUM_W+1)'({cnt_reg, {FRAC_W{1'b0}}}));
            default:  res = $signed((SUM_W+1)'(sq_root));
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            distance_reg <= sat_dist(res);
        end
    end

    assign distance       = distance_reg;
    assign stat.pipe_busy = v1_reg | v2_reg;
    assign stat.sq_busy   = sq_busy;
    assign stat.div_busy  = (dcnt_reg != '0);

endmodule

[sv/vde_ctrl.sv]
module vde_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [vde_pkg::MET_W-1:0] metric,
    input  logic                      in_valid,
    input  logic                      last_elem,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    input  vde_pkg::vde_stat_t        stat,
    output vde_pkg::vde_cmd_t         cmd
);
    import vde_pkg::*;

    typedef enum logic [2:0] {
        S_RUN,
        S_FLUSH,
        S_SQ,
        S_SQA,
        S_SQB,
        S_DIVS,
        S_DIV,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.accept = (state_reg == S_RUN) && in_valid;

        case (state_reg)
            S_RUN:
            begin
                if (in_valid && last_elem)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                // wait until the last word has reached the sums
                if (!stat.pipe_busy)
                begin
                    case (metric)
                        MET_L2SQ, MET_NIP, MET_L1, MET_HAM:
                        begin
                            state_next = S_FIN;
                        end
                        MET_COS:
                        begin
                            cmd.sq_start = 1'b1;
                            cmd.sq_src   = SQ_SRC_NA;
                            state_next   = S_SQA;
                        end
                        default:
                        begin
                            cmd.sq_start = 1'b1;
                            cmd.sq_src   = SQ_SRC_DIFF;
                            state_next   = S_SQ;
                        end
                    endcase
                end
            end
            S_SQ:
            begin
                if (!stat.sq_busy)
                begin
                    state_next = S_FIN;
                end
            end
            S_SQA:
            begin
                if (!stat.sq_busy)
                begin
                    cmd.save_ra  = 1'b1;
                    cmd.sq_start = 1'b1;
                    cmd.sq_src   = SQ_SRC_NB;
                    state_next   = S_SQB;
                end
            end
            S_SQB:
            begin
                if (!stat.sq_busy)
                begin
                    cmd.mul_go = 1'b1;
                    state_next = S_DIVS;
                end
            end
            S_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_RUN);
    assign out_valid = out_valid_reg;

endmodule
